// File: src/wstoi_pkg.sv
// shared constants, types and status codes of the wide string integer parser
package wstoi_pkg;

  localparam int VALUE_BITS   = 64;
  localparam int OFFSET_BITS  = 32;
  localparam int UNIT_W       = 16;
  localparam int OUT_VALUE_W  = 64;
  localparam int OUT_OFFSET_W = 32;
  localparam int RADIX_W      = 6;
  localparam int DIGIT_W      = 6;
  localparam int FIFO_DEPTH   = 2;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam int RADIX_OCT = 8;
  localparam int RADIX_DEC = 10;
  localparam int RADIX_HEX = 16;
  localparam int RADIX_MAX = 36;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = RADIX_W'(RADIX_DEC);
  localparam logic               SIGNED_RESET = 1'b1;

  typedef enum logic [0:0] {
    REG_RADIX       = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_RANGE     = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_t;

  typedef struct packed {
    logic               first;
    logic               ws;
    logic               plus;
    logic               minus;
    logic               zero;
    logic               xch;
    logic               dok;
    logic [DIGIT_W-1:0] dval;
  } unit_class_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

endpackage

// File: src/wstoi_in_if.sv
// input channel: one utf-16 code unit per beat
interface wstoi_in_if import wstoi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              first_unit;

  modport source(output valid, code_unit, first_unit, input ready);
  modport sink(input valid, code_unit, first_unit, output ready);
endinterface

// File: src/wstoi_out_if.sv
// result channel: parsed value, end offset and status per beat
interface wstoi_out_if import wstoi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OUT_VALUE_W-1:0]  value;
  logic [OUT_OFFSET_W-1:0] end_offset;
  logic [1:0]              status;

  modport source(output valid, value, end_offset, status, input ready);
  modport sink(input valid, value, end_offset, status, output ready);
endinterface

// File: src/wstoi_cfg.sv
// apb register file holding radix and signed mode
module wstoi_cfg import wstoi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [RADIX_W-1:0] radix_r;
  logic               signed_mode_r;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= RADIX_RESET;
      signed_mode_r <= SIGNED_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_RADIX:       radix_r       <= pwdata[RADIX_W-1:0];
        REG_SIGNED_MODE: signed_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RADIX:       prdata = CFG_DW'(radix_r);
      REG_SIGNED_MODE: prdata = CFG_DW'(signed_mode_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.radix       = radix_r;
  assign cfg.signed_mode = signed_mode_r;

endmodule

// File: src/wstoi_front.sv
// front end: accepts code units, classifies them and queues them for the back end
module wstoi_front import wstoi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wstoi_in_if.sink    in_beat,
  output unit_class_t q_data,
  output logic        q_valid,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  unit_class_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r;
  logic [PTR_W-1:0]       rd_ptr_r;
  logic [CNT_W-1:0]       count_r;
  logic                   push;
  unit_class_t            cls;
  logic [UNIT_W-1:0]      c;

  assign c = in_beat.code_unit;

  always_comb begin
    cls       = '0;
    cls.first = in_beat.first_unit;
    cls.ws    = (c == UNIT_W'(16'h0020)) || (c >= UNIT_W'(16'h0009) && c <= UNIT_W'(16'h000D));
    cls.plus  = (c == UNIT_W'(16'h002B));
    cls.minus = (c == UNIT_W'(16'h002D));
    cls.zero  = (c == UNIT_W'(16'h0030));
    cls.xch   = (c == UNIT_W'(16'h0078)) || (c == UNIT_W'(16'h0058));
    if (c >= UNIT_W'(16'h0030) && c <= UNIT_W'(16'h0039)) begin
      cls.dok  = 1'b1;
      cls.dval = DIGIT_W'(c - UNIT_W'(16'h0030));
    end else if (c >= UNIT_W'(16'h0061) && c <= UNIT_W'(16'h007A)) begin
      cls.dok  = 1'b1;
      cls.dval = DIGIT_W'(c - UNIT_W'(16'h0061) + UNIT_W'(RADIX_DEC));
    end else if (c >= UNIT_W'(16'h0041) && c <= UNIT_W'(16'h005A)) begin
      cls.dok  = 1'b1;
      cls.dval = DIGIT_W'(c - UNIT_W'(16'h0041) + UNIT_W'(RADIX_DEC));
    end
  end

  assign in_beat.ready = (count_r != CNT_W'(FIFO_DEPTH));
  assign push          = in_beat.valid && in_beat.ready;
  assign q_valid       = (count_r != '0);
  assign q_data        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && q_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/wstoi_back.sv
// back end: parse state machine, accumulator with overflow check and result register
module wstoi_back import wstoi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  unit_class_t q_data,
  input  logic        q_valid,
  output logic        q_pop,
  input  cfg_t        cfg,
  wstoi_out_if.source out_beat
);

  localparam int PROD_W = VALUE_BITS + RADIX_W;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_LEAD   = 7'b0000010,
    PH_SIGNED = 7'b0000100,
    PH_ZERO   = 7'b0001000,
    PH_ZEROX  = 7'b0010000,
    PH_DIGITS = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  localparam logic [VALUE_BITS-1:0] VMAX = '1;
  localparam logic [VALUE_BITS-1:0] SMAX = VMAX >> 1;
  localparam logic [VALUE_BITS-1:0] SMIN = ~SMAX;

  phase_t                  phase_r, phase_nxt, ph;
  logic [RADIX_W-1:0]      base_r, base_nxt;
  logic                    neg_r, neg_nxt;
  logic                    seen_r, seen_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt, pos_cur;
  logic [OFFSET_BITS-1:0]  pm_r, pm_nxt;
  logic                    us_r, us_nxt;

  logic                    out_valid_r;
  logic [OUT_VALUE_W-1:0]  out_value_r;
  logic [OUT_OFFSET_W-1:0] out_offset_r;
  status_t                 out_status_r;

  logic                    adv, active, start, do_dig, fin;
  logic [OFFSET_BITS-1:0]  fin_off;
  logic [PROD_W-1:0]       prod;
  logic                    emit;
  logic [VALUE_BITS-1:0]   emit_val;
  logic [OFFSET_BITS-1:0]  emit_off;
  status_t                 emit_st;
  unit_class_t             u;

  assign u     = q_data;
  assign adv   = q_valid && (!out_valid_r || out_beat.ready);
  assign q_pop = adv;

  always_comb begin
    ph       = phase_r;
    base_nxt = base_r;
    neg_nxt  = neg_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    acc_nxt  = acc_r;
    pos_cur  = pos_r;
    pm_nxt   = pm_r;
    us_nxt   = us_r;
    if (u.first) begin
      ph       = PH_LEAD;
      base_nxt = cfg.radix;
      us_nxt   = cfg.signed_mode;
      neg_nxt  = 1'b0;
      seen_nxt = 1'b0;
      ovf_nxt  = 1'b0;
      acc_nxt  = '0;
      pos_cur  = '0;
      pm_nxt   = '0;
    end
    active    = u.first || (ph != PH_IDLE && ph != PH_DONE);
    phase_nxt = ph;
    start     = 1'b0;
    do_dig    = 1'b0;
    fin       = 1'b0;
    fin_off   = '0;
    emit      = 1'b0;
    emit_val  = '0;
    emit_off  = '0;
    emit_st   = ST_OK;

    unique case (ph)
      PH_LEAD: begin
        if (u.ws) begin
          phase_nxt = PH_LEAD;
        end else if (u.plus) begin
          phase_nxt = PH_SIGNED;
        end else if (u.minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGNED: start = 1'b1;
      PH_ZERO: begin
        if (u.xch) begin
          pm_nxt    = pos_cur;
          phase_nxt = PH_ZEROX;
        end else begin
          base_nxt  = (base_nxt == '0) ? RADIX_W'(RADIX_OCT) : RADIX_W'(RADIX_HEX);
          seen_nxt  = 1'b1;
          acc_nxt   = '0;
          phase_nxt = PH_DIGITS;
          do_dig    = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (u.dok && u.dval < DIGIT_W'(RADIX_HEX)) begin
          base_nxt  = RADIX_W'(RADIX_HEX);
          phase_nxt = PH_DIGITS;
          do_dig    = 1'b1;
        end else begin
          base_nxt = (base_nxt == '0) ? RADIX_W'(RADIX_OCT) : RADIX_W'(RADIX_HEX);
          seen_nxt = 1'b1;
          acc_nxt  = '0;
          fin      = 1'b1;
          fin_off  = pm_nxt;
        end
      end
      PH_DIGITS: do_dig = 1'b1;
      PH_IDLE, PH_DONE: ;
      default: ;
    endcase

    if (start) begin
      if (base_nxt == RADIX_W'(1) || base_nxt > RADIX_W'(RADIX_MAX)) begin
        emit      = 1'b1;
        emit_st   = ST_BAD_BASE;
        phase_nxt = PH_DONE;
      end else if ((base_nxt == '0 || base_nxt == RADIX_W'(RADIX_HEX)) && u.zero) begin
        phase_nxt = PH_ZERO;
      end else begin
        if (base_nxt == '0) begin
          base_nxt = RADIX_W'(RADIX_DEC);
        end
        phase_nxt = PH_DIGITS;
        do_dig    = 1'b1;
      end
    end

    prod = PROD_W'(acc_nxt) * PROD_W'(base_nxt) + PROD_W'(u.dval);

    if (do_dig) begin
      if (!u.dok || u.dval >= DIGIT_W'(base_nxt)) begin
        fin     = 1'b1;
        fin_off = seen_nxt ? pos_cur : '0;
      end else begin
        seen_nxt = 1'b1;
        if (!ovf_nxt) begin
          if (prod[PROD_W-1:VALUE_BITS] != '0) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[VALUE_BITS-1:0];
          end
        end
      end
    end

    if (fin) begin
      emit      = 1'b1;
      phase_nxt = PH_DONE;
      emit_off  = fin_off;
      if (!seen_nxt) begin
        emit_st  = ST_NO_DIGITS;
        emit_off = '0;
      end else if (!us_nxt) begin
        if (ovf_nxt) begin
          emit_val = VMAX;
          emit_st  = ST_RANGE;
        end else begin
          emit_val = neg_nxt ? (VALUE_BITS'(0) - acc_nxt) : acc_nxt;
        end
      end else if (neg_nxt) begin
        if (ovf_nxt || (acc_nxt[VALUE_BITS-1] && acc_nxt[VALUE_BITS-2:0] != '0)) begin
          emit_val = SMIN;
          emit_st  = ST_RANGE;
        end else begin
          emit_val = VALUE_BITS'(0) - acc_nxt;
        end
      end else begin
        if (ovf_nxt || acc_nxt[VALUE_BITS-1]) begin
          emit_val = SMAX;
          emit_st  = ST_RANGE;
        end else begin
          emit_val = acc_nxt;
        end
      end
    end

    pos_nxt = pos_cur;
    if (active && pos_cur != '1) begin
      pos_nxt = pos_cur + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      base_r  <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      acc_r   <= '0;
      pos_r   <= '0;
      pm_r    <= '0;
      us_r    <= SIGNED_RESET;
    end else if (adv) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      pm_r    <= pm_nxt;
      us_r    <= us_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_value_r  <= OUT_VALUE_W'(emit_val);
      out_offset_r <= OUT_OFFSET_W'(emit_off);
      out_status_r <= emit_st;
    end
  end

  assign out_beat.valid      = out_valid_r;
  assign out_beat.value      = out_value_r;
  assign out_beat.end_offset = out_offset_r;
  assign out_beat.status     = out_status_r;

endmodule

// File: src/wide_string_to_integer_parser.sv
// top level of the streaming wide string to integer parser
//
// usage
// - in_beat carries one utf-16 code unit per beat; first_unit marks the
//   first unit of a string and restarts the parse, dropping any parse
//   in progress without a result
// - out_beat carries one result per string: value, end_offset, status
//   (ok, no digits, out of range with clamped value, invalid base)
// - radix and signed_mode sit at apb byte addresses 0 and 4; they are
//   sampled with each first unit and should be written while idle
// - one code unit is taken per cycle while the queue has room; the
//   terminating unit's result passes the queue, then the
//   state machine with its 64 by 6 bit multiply-add into the result register
// - units after a result and before the next first unit are dropped
// - a stalled result register holds the parse; the two-entry queue keeps
//   accepting until it fills, then in_beat.ready falls
// - reset returns to idle with radix 10 and signed mode on, and no
//   result pending
module wide_string_to_integer_parser import wstoi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wstoi_in_if.sink          in_beat,
  wstoi_out_if.source       out_beat,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  unit_class_t q_data;
  logic        q_valid;
  logic        q_pop;
  cfg_t        cfg;

  wstoi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wstoi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  wstoi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .cfg      (cfg),
    .out_beat (out_beat)
  );

endmodule

// File: src/wstoi_checker.sv
// port-level checks of the parser, bound to the top level
module wstoi_checker import wstoi_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [OUT_VALUE_W-1:0]  out_value,
  input logic [OUT_OFFSET_W-1:0] out_end_offset,
  input logic [1:0]              out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_end_offset) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_DIGITS |-> out_value == '0 && out_end_offset == '0)
    else $error("no-digit result with nonzero value or offset");

  a_bad_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_BASE |-> out_value == '0 && out_end_offset == '0)
    else $error("invalid-base result with nonzero value or offset");

endmodule

bind wide_string_to_integer_parser wstoi_checker u_wstoi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_beat.valid),
  .out_ready      (out_beat.ready),
  .out_value      (out_beat.value),
  .out_end_offset (out_beat.end_offset),
  .out_status     (out_beat.status)
);
